// ----- hw/rtl/bad_pkg.sv -----
// Package with the shared types and codes of the box average downscaler.
package bad_pkg;

   localparam int unsigned DIM_W   = 13;
   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned SUM_W   = 32;
   localparam int unsigned CNT_W   = 2 * DIM_W;
   localparam int unsigned NUM_CH  = 4;
   localparam int unsigned QUO_W   = 8;

   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      AVG_IDLE,
      AVG_RUN,
      AVG_DONE
   } avg_state_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_in;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               last_of_frame;
   } rsp_payload_type;

endpackage

// ----- hw/rtl/bad_stream_if.sv -----
// Valid/ready stream interface that carries one payload struct per transaction.
interface bad_stream_if #(
   parameter type PAYLOAD_TYPE = bad_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/bad_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module bad_ram #(
   parameter int unsigned WIDTH = 128,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/box_average_downscale_argb.sv -----
// Top level of the box average ARGB downscaler.
//
// Source pixels enter on req_chan in raster order, one per transaction; averaged
// pixels leave on rsp_chan with last_of_frame set on the final one of a frame.
// The csr_ port sets the source and output sizes; each write starts a
// computation of the scale factors, during which req_chan is not ready.
// Pixels that do not complete a box are taken one per cycle while the divider
// is idle. Column sums live in one RAM row per output column, read when a
// pixel is taken and written back the next cycle, with the previous write
// forwarded to a read of the same row. A pixel that completes a box starts a
// bit-serial divide of the four channel sums; the next pixel is taken only once
// the divider is idle again, and the result is registered for rsp_chan.
// A finished result waits in the output register while new pixels are taken;
// when the receiver stalls and the next box completes, the divider holds its
// result and req_chan drops ready until the output register is free.
// Reset clears all sizes, positions and handshake state; the RAM is not
// cleared, since every row is written by the first pixel of its box.
module box_average_downscale_argb #(
   parameter int unsigned MAX_DST_WIDTH = 4096,
   parameter int unsigned MAX_FRAME_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   bad_stream_if.sink   req_chan,
   bad_stream_if.source rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import bad_pkg::*;

   localparam int unsigned AW    = $clog2(MAX_DST_WIDTH);
   localparam int unsigned RAM_W = NUM_CH * SUM_W;
   localparam logic [DIM_W:0] MAX_DW = (DIM_W+1)'(MAX_DST_WIDTH);
   localparam logic [DIM_W:0] MAX_FD = (DIM_W+1)'(MAX_FRAME_DIM);

   // Configuration registers.
   logic [DIM_W-1:0] sw_ff, sh_ff, dw_ff, dh_ff;

   // Factor computation sequencer.
   logic [3:0]       calc_cnt_ff;
   logic [DIM_W-1:0] fxn_ff, fxr_ff, fyn_ff, fyr_ff;
   logic [DIM_W-1:0] fx_ff, fy_ff;
   logic [CNT_W-1:0] bw_ff, bh_ff, cnt_ff;
   logic             cfg_ok_ff;
   logic [DIM_W:0]   fx_trial, fy_trial;
   logic             sizes_ok;

   always_comb begin
      fx_trial = {fxr_ff, fxn_ff[DIM_W-1]};
      fy_trial = {fyr_ff, fyn_ff[DIM_W-1]};
      sizes_ok = sw_ff != '0 && sh_ff != '0 && dw_ff != '0 && dh_ff != '0 &&
                 {1'b0, dw_ff} <= MAX_DW &&
                 {1'b0, sw_ff} <= MAX_FD && {1'b0, sh_ff} <= MAX_FD &&
                 {1'b0, dw_ff} <= MAX_FD && {1'b0, dh_ff} <= MAX_FD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff       <= '0;
         sh_ff       <= '0;
         dw_ff       <= '0;
         dh_ff       <= '0;
         calc_cnt_ff <= '0;
         cfg_ok_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  sw_ff <= csr_wdata;
            CSR_SRC_HEIGHT: sh_ff <= csr_wdata;
            CSR_DST_WIDTH:  dw_ff <= csr_wdata;
            CSR_DST_HEIGHT: dh_ff <= csr_wdata;
            default: ;
         endcase
         calc_cnt_ff <= 4'd15;
         cfg_ok_ff   <= 1'b0;
      end else if (calc_cnt_ff == 4'd1) begin
         calc_cnt_ff <= '0;
         cfg_ok_ff   <= sizes_ok && fxn_ff != '0 && fyn_ff != '0;
      end else if (calc_cnt_ff != '0) begin
         calc_cnt_ff <= calc_cnt_ff - 4'd1;
      end
   end

   // Restoring division, one quotient bit per cycle; the quotient shifts into
   // the dividend register as the dividend bits shift out.
   always_ff @(posedge clock) begin
      if (calc_cnt_ff == 4'd15) begin
         fxn_ff <= sw_ff;
         fyn_ff <= sh_ff;
         fxr_ff <= '0;
         fyr_ff <= '0;
      end else if (calc_cnt_ff >= 4'd2) begin
         if (fx_trial >= {1'b0, dw_ff}) begin
            fxr_ff <= DIM_W'(fx_trial - {1'b0, dw_ff});
            fxn_ff <= {fxn_ff[DIM_W-2:0], 1'b1};
         end else begin
            fxr_ff <= fx_trial[DIM_W-1:0];
            fxn_ff <= {fxn_ff[DIM_W-2:0], 1'b0};
         end
         if (fy_trial >= {1'b0, dh_ff}) begin
            fyr_ff <= DIM_W'(fy_trial - {1'b0, dh_ff});
            fyn_ff <= {fyn_ff[DIM_W-2:0], 1'b1};
         end else begin
            fyr_ff <= fy_trial[DIM_W-1:0];
            fyn_ff <= {fyn_ff[DIM_W-2:0], 1'b0};
         end
      end else if (calc_cnt_ff == 4'd1) begin
         fx_ff  <= fxn_ff;
         fy_ff  <= fyn_ff;
         bw_ff  <= dw_ff * fxn_ff;
         bh_ff  <= dh_ff * fyn_ff;
         cnt_ff <= fxn_ff * fyn_ff;
      end
   end

   // Position state, updated when a pixel is accepted while the source size is nonzero.
   logic [DIM_W-1:0] col_ff, row_ff, bcp_ff, brp_ff, oc_ff;
   logic [DIM_W-1:0] col_in, row_in, bcp_in, brp_in, oc_in;
   logic             accept, active, in_box, col_done, row_done, emit, last, first;

   avg_state_type avg_state_ff, avg_state_in;
   logic          s1_valid_ff, s1_first_ff, s1_emit_ff, s1_last_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;

   assign req_chan.ready = calc_cnt_ff == '0 && avg_state_ff == AVG_IDLE &&
                           !(s1_valid_ff && s1_emit_ff);
   assign accept = req_chan.valid && req_chan.ready;
   assign active = sw_ff != '0 && sh_ff != '0;

   always_comb begin
      in_box   = cfg_ok_ff && CNT_W'(col_ff) < bw_ff && CNT_W'(row_ff) < bh_ff &&
                 oc_ff < dw_ff;
      col_done = {1'b0, bcp_ff} + 14'd1 >= {1'b0, fx_ff};
      row_done = {1'b0, brp_ff} + 14'd1 >= {1'b0, fy_ff};
      first    = bcp_ff == '0 && brp_ff == '0;
      emit     = in_box && col_done && row_done;
      last     = {1'b0, oc_ff} + 14'd1 == {1'b0, dw_ff} &&
                 CNT_W'(row_ff) + CNT_W'(1) == bh_ff;

      col_in = col_ff;
      row_in = row_ff;
      bcp_in = bcp_ff;
      brp_in = brp_ff;
      oc_in  = oc_ff;
      if (in_box) begin
         if (col_done) begin
            bcp_in = '0;
            oc_in  = oc_ff + DIM_W'(1);
         end else begin
            bcp_in = bcp_ff + DIM_W'(1);
         end
      end
      if ({1'b0, col_ff} + 14'd1 >= {1'b0, sw_ff}) begin
         col_in = '0;
         bcp_in = '0;
         oc_in  = '0;
         if ({1'b0, row_ff} + 14'd1 >= {1'b0, sh_ff}) begin
            row_in = '0;
            brp_in = '0;
         end else begin
            row_in = row_ff + DIM_W'(1);
            if (cfg_ok_ff && !row_done) begin
               brp_in = brp_ff + DIM_W'(1);
            end else begin
               brp_in = '0;
            end
         end
      end else begin
         col_in = col_ff + DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         bcp_ff      <= '0;
         brp_ff      <= '0;
         oc_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && active && in_box;
         if (accept && active) begin
            col_ff <= col_in;
            row_ff <= row_in;
            bcp_ff <= bcp_in;
            brp_ff <= brp_in;
            oc_ff  <= oc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= first;
      s1_emit_ff  <= emit;
      s1_last_ff  <= last;
      s1_addr_ff  <= oc_ff[AW-1:0];
      s1_pixel_ff <= req_chan.payload.pixel_in;
   end

   // Read-modify-write of the column sums, forwarding the previous cycle's write.
   logic [RAM_W-1:0] rd_data, base, new_sum;
   logic [RAM_W-1:0] wr_data_ff;
   logic [AW-1:0]    wr_addr_ff;
   logic             wr_valid_ff;

   bad_ram #(.WIDTH(RAM_W), .DEPTH(MAX_DST_WIDTH)) u_sum_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (new_sum),
      .rd_addr (oc_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      if (s1_first_ff) begin
         base = '0;
      end else if (wr_valid_ff && wr_addr_ff == s1_addr_ff) begin
         base = wr_data_ff;
      end else begin
         base = rd_data;
      end
      for (int c = 0; c < NUM_CH; c++) begin
         new_sum[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W] +
                                     SUM_W'(s1_pixel_ff[c*8 +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else begin
         wr_valid_ff <= s1_valid_ff;
      end
      wr_addr_ff <= s1_addr_ff;
      wr_data_ff <= new_sum;
   end

   // Bit-serial average: eight restoring steps give the 8-bit mean per channel.
   logic [SUM_W-1:0]   rem_ff [NUM_CH];
   logic [QUO_W-1:0]   quo_ff [NUM_CH];
   logic [SUM_W:0]     dsh_ff;
   logic [2:0]         step_ff;
   logic               avg_last_ff;
   logic               avg_load, avg_step, avg_deliver;
   logic               out_valid_ff, out_last_ff;
   logic [PIXEL_W-1:0] out_pixel_ff;
   logic               out_free;

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      avg_state_in = avg_state_ff;
      unique case (avg_state_ff)
         AVG_IDLE: if (s1_valid_ff && s1_emit_ff) avg_state_in = AVG_RUN;
         AVG_RUN:  if (step_ff == 3'd7) avg_state_in = AVG_DONE;
         AVG_DONE: if (out_free) avg_state_in = AVG_IDLE;
         default:  avg_state_in = AVG_IDLE;
      endcase
   end

   always_comb begin
      avg_load    = 1'b0;
      avg_step    = 1'b0;
      avg_deliver = 1'b0;
      unique case (avg_state_ff)
         AVG_IDLE: avg_load    = s1_valid_ff && s1_emit_ff;
         AVG_RUN:  avg_step    = 1'b1;
         AVG_DONE: avg_deliver = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_state_ff <= AVG_IDLE;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         avg_state_ff <= avg_state_in;
         if (avg_load) begin
            step_ff <= '0;
         end else if (avg_step) begin
            step_ff <= step_ff + 3'd1;
         end
         if (avg_deliver) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (avg_load) begin
         for (int c = 0; c < NUM_CH; c++) begin
            rem_ff[c] <= new_sum[c*SUM_W +: SUM_W];
            quo_ff[c] <= '0;
         end
         dsh_ff      <= (SUM_W+1)'({cnt_ff, 7'b0});
         avg_last_ff <= s1_last_ff;
      end else if (avg_step) begin
         for (int c = 0; c < NUM_CH; c++) begin
            if ({1'b0, rem_ff[c]} >= dsh_ff) begin
               rem_ff[c] <= rem_ff[c] - dsh_ff[SUM_W-1:0];
               quo_ff[c] <= {quo_ff[c][QUO_W-2:0], 1'b1};
            end else begin
               quo_ff[c] <= {quo_ff[c][QUO_W-2:0], 1'b0};
            end
         end
         dsh_ff <= dsh_ff >> 1;
      end
      if (avg_deliver) begin
         out_pixel_ff <= {quo_ff[3], quo_ff[2], quo_ff[1], quo_ff[0]};
         out_last_ff  <= avg_last_ff;
      end
   end

   assign rsp_chan.valid                 = out_valid_ff;
   assign rsp_chan.payload.pixel_out     = out_pixel_ff;
   assign rsp_chan.payload.last_of_frame = out_last_ff;
endmodule

// ----- tb/box_average_downscale_argb_checker.sv -----
// Checker that predicts and compares the averaged pixels of the downscaler.
module box_average_downscale_argb_checker (
   input  logic        clock,
   input  logic        reset,
   bad_stream_if.sink  req_mon,
   bad_stream_if.sink  rsp_mon,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bad_pkg::*;

   localparam int unsigned MAX_DST = 4096;
   localparam int unsigned MAX_DIM = 4096;

   logic [12:0] src_w, src_h, dst_w, dst_h;
   logic [31:0] acc_a [MAX_DST];
   logic [31:0] acc_r [MAX_DST];
   logic [31:0] acc_g [MAX_DST];
   logic [31:0] acc_b [MAX_DST];
   logic [12:0] col_pos, row_pos, box_col, box_row, out_col;
   rsp_payload_type expected_pixels[$];

   // Advances the predicted downscaler state by one source pixel.
   task automatic predict_pixel(input logic [31:0] pix);
      int unsigned fx, fy, i, cnt;
      bit ok;
      rsp_payload_type res;
      fx = 0;
      fy = 0;
      ok = src_w != 0 && src_h != 0 && dst_w != 0 && dst_h != 0 && dst_w <= MAX_DST &&
           src_w <= MAX_DIM && src_h <= MAX_DIM && dst_w <= MAX_DIM && dst_h <= MAX_DIM;
      if (ok) begin
         fx = 32'(src_w) / 32'(dst_w);
         fy = 32'(src_h) / 32'(dst_h);
         ok = fx != 0 && fy != 0;
      end
      if (src_w == 0 || src_h == 0) return;
      if (ok && col_pos < dst_w * fx && row_pos < dst_h * fy && out_col < dst_w) begin
         i = 32'(out_col);
         if (box_row == 0 && box_col == 0) begin
            acc_a[i] = 32'(pix[31:24]);
            acc_r[i] = 32'(pix[23:16]);
            acc_g[i] = 32'(pix[15:8]);
            acc_b[i] = 32'(pix[7:0]);
         end else begin
            acc_a[i] += 32'(pix[31:24]);
            acc_r[i] += 32'(pix[23:16]);
            acc_g[i] += 32'(pix[15:8]);
            acc_b[i] += 32'(pix[7:0]);
         end
         if (box_col + 1 >= fx && box_row + 1 >= fy) begin
            cnt = fx * fy;
            res.pixel_out = {8'(acc_a[i] / cnt), 8'(acc_r[i] / cnt),
                             8'(acc_g[i] / cnt), 8'(acc_b[i] / cnt)};
            res.last_of_frame = (i + 1 == dst_w) && (row_pos + 1 == dst_h * fy);
            expected_pixels.push_back(res);
         end
         if (box_col + 1 >= fx) begin
            box_col = '0;
            out_col = out_col + 13'd1;
         end else begin
            box_col = box_col + 13'd1;
         end
      end
      if (col_pos + 1 >= src_w) begin
         col_pos = '0;
         box_col = '0;
         out_col = '0;
         if (row_pos + 1 >= src_h) begin
            row_pos = '0;
            box_row = '0;
         end else begin
            row_pos = row_pos + 13'd1;
            if (ok && box_row + 1 < fy) box_row = box_row + 13'd1;
            else box_row = '0;
         end
      end else begin
         col_pos = col_pos + 13'd1;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         src_w = '0;
         src_h = '0;
         dst_w = '0;
         dst_h = '0;
         col_pos = '0;
         row_pos = '0;
         box_col = '0;
         box_row = '0;
         out_col = '0;
         expected_pixels.delete();
         fail_count = 0;
      end else begin
         // Results are compared before the new pixel is predicted, since a result
         // can never leave in the same cycle as the pixel that causes it.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected result pixel %h last %b", $time,
                        rsp_mon.payload.pixel_out, rsp_mon.payload.last_of_frame);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (want.pixel_out !== rsp_mon.payload.pixel_out) begin
                  $display("%0t: pixel_out expected %h actual %h", $time,
                           want.pixel_out, rsp_mon.payload.pixel_out);
                  fail_count++;
               end
               if (want.last_of_frame !== rsp_mon.payload.last_of_frame) begin
                  $display("%0t: last_of_frame expected %b actual %b", $time,
                           want.last_of_frame, rsp_mon.payload.last_of_frame);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) predict_pixel(req_mon.payload.pixel_in);
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_SRC_WIDTH:  src_w = csr_wdata;
               CSR_SRC_HEIGHT: src_h = csr_wdata;
               CSR_DST_WIDTH:  dst_w = csr_wdata;
               CSR_DST_HEIGHT: dst_h = csr_wdata;
            endcase
         end
      end
      pending_count = expected_pixels.size();
   end
endmodule

// ----- tb/box_average_downscale_argb_tb.sv -----
// Top of the downscaler testbench: clock, reset, stimulus and the verdict.
module box_average_downscale_argb_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bad_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [12:0] csr_wdata;
   int          fail_count;
   int          pending_count;
   bit          calm;
   bit          hold_rsp;
   int          idle_cycles;

   bad_stream_if #(.PAYLOAD_TYPE(req_payload_type)) req_chan ();
   bad_stream_if #(.PAYLOAD_TYPE(rsp_payload_type)) rsp_chan ();

   box_average_downscale_argb dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   box_average_downscale_argb_checker checker_inst (
      .clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // Receiver: random stall bursts, or one long hold-off when asked.
   initial begin
      int n;
      rsp_chan.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_chan.ready <= 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 17);
            rsp_chan.ready <= 0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Leaves the write enable high; set_sizes drops it after the last write.
   task automatic write_reg(input csr_index_type idx, input logic [12:0] value);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // Waits for all results, then for the divider to finish any box in flight.
   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_sizes(input logic [12:0] sw, sh, dw, dh);
      drain();
      write_reg(CSR_SRC_WIDTH, sw);
      write_reg(CSR_SRC_HEIGHT, sh);
      write_reg(CSR_DST_WIDTH, dw);
      write_reg(CSR_DST_HEIGHT, dh);
      csr_we <= 0;
   endtask

   // Ready depends on registers only, so its value at the falling edge is the
   // value at the next rising edge.
   task automatic send_pixel(input logic [31:0] pix, input bit gaps);
      int n;
      if (gaps && !calm && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 17);
         req_chan.valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.payload.pixel_in <= pix;
      while (!req_chan.ready) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame(input int count, input int style);
      logic [31:0] pix;
      for (int k = 0; k < count; k++) begin
         case (style)
            0: pix = $urandom;
            1: pix = (k % 2) ? 32'hFFFF_FFFF : 32'h0000_0000;
            default: pix = 32'hFFFF_FFFF;
         endcase
         send_pixel(pix, 1);
      end
      req_chan.valid <= 0;
      @(negedge clock);
   endtask

   initial begin
      int sw, sh, dw, dh, sent;
      calm = 0;
      hold_rsp = 0;
      reset = 1;
      csr_we = 0;
      csr_index = CSR_SRC_WIDTH;
      csr_wdata = '0;
      req_chan.valid = 0;
      req_chan.payload = '0;
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: registers still zero, so nothing should come out.
      send_frame(2, 0);
      // Single pixel frames; one by one boxes of all ones, then of all zeros.
      set_sizes(13'd1, 13'd1, 13'd1, 13'd1);
      send_frame(1, 2);
      send_frame(1, 1);
      // An excess column is dropped: 5x3 onto 2x1 with 2x3 boxes.
      set_sizes(13'd5, 13'd3, 13'd2, 13'd1);
      send_frame(15, 1);
      // Zero output size and a factor of zero disable the frame.
      set_sizes(13'd4, 13'd2, 13'd0, 13'd1);
      send_frame(4, 0);
      set_sizes(13'd2, 13'd2, 13'd3, 13'd1);
      send_frame(4, 0);

      // Long receiver hold-off while the sender keeps offering.
      set_sizes(13'd4, 13'd4, 13'd4, 13'd4);
      hold_rsp = 1;
      send_frame(16, 0);
      // Sender pause until everything has come back.
      while (pending_count != 0) @(negedge clock);

      sent = 0;
      while (sent < 690) begin
         if (sent > 540) calm = 1;
         sw = $urandom_range(1, 12);
         sh = $urandom_range(1, 6);
         dw = $urandom_range(1, sw);
         dh = $urandom_range(1, sh);
         if ($urandom_range(0, 15) == 0) dw = 0;
         set_sizes(13'(sw), 13'(sh), 13'(dw), 13'(dh));
         send_frame(sw * sh, 0);
         sent += sw * sh;
      end
      // Wide row of large boxes with two excess columns at its end.
      set_sizes(13'd320, 13'd1, 13'd3, 13'd1);
      send_frame(320, 0);

      drain();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
